>>> src/ldc_pkg.sv
// Shared types and constants for the label overlap declutter block.
package ldc_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned CoordBitsDef  = 16;

  localparam int unsigned InCoordW = 16;
  localparam int unsigned CntW     = 9;
  localparam int unsigned MaxLblW  = 8;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_CHECK    = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_SATURATE = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UNCHECKED = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_OUTSIDE   = 3'd4,
    ST_OVERLAP   = 3'd5,
    ST_CONTROL   = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE      = 3'd0,
    REG_MAX_LABELS  = 3'd1,
    REG_CLIP_LEFT   = 3'd2,
    REG_CLIP_RIGHT  = 3'd3,
    REG_CLIP_TOP    = 3'd4,
    REG_CLIP_BOTTOM = 3'd5
  } cfg_idx_e;

  // Scan token handed from cell to cell along the chain.
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [CntW-1:0] count;
  } tok_t;

endpackage

>>> src/ldc_cell.sv
// One table slot: holds a stored rectangle and tests the passing candidate against it.
module ldc_cell #(
  parameter int unsigned COORD_BITS = ldc_pkg::CoordBitsDef,
  parameter int unsigned IDX        = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ldc_pkg::tok_t                tok_i,
  input  logic signed [COORD_BITS-1:0] l_i,
  input  logic signed [COORD_BITS-1:0] t_i,
  input  logic signed [COORD_BITS-1:0] r_i,
  input  logic signed [COORD_BITS-1:0] b_i,
  output ldc_pkg::tok_t                tok_o,
  output logic signed [COORD_BITS-1:0] l_o,
  output logic signed [COORD_BITS-1:0] t_o,
  output logic signed [COORD_BITS-1:0] r_o,
  output logic signed [COORD_BITS-1:0] b_o
);

  logic signed [COORD_BITS-1:0] s_l_q, s_t_q, s_r_q, s_b_q;
  logic signed [COORD_BITS-1:0] l_q, t_q, r_q, b_q;
  logic                         tok_valid_q;
  logic                         tok_hit_q, tok_hit_d;
  logic [ldc_pkg::CntW-1:0]     tok_count_q;
  logic                         in_use;
  logic                         at_tail;
  logic                         overlap;
  logic                         wr_en;

  // Only slots below the fill count hold live rectangles.
  assign in_use  = 32'(IDX) < 32'(tok_i.count);
  assign at_tail = 32'(IDX) == 32'(tok_i.count);

  assign overlap = in_use &&
                   !((l_i >= s_r_q) || (r_i <= s_l_q) || (t_i >= s_b_q) || (b_i <= s_t_q));

  assign tok_hit_d = tok_i.hit | (tok_i.valid & overlap);

  // Every live slot lies ahead of the tail slot, so the hit flag is final here.
  assign wr_en = tok_i.valid && at_tail && !tok_i.hit;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      s_l_q <= l_i;
      s_t_q <= t_i;
      s_r_q <= r_i;
      s_b_q <= b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_hit_q   <= tok_hit_d;
    tok_count_q <= tok_i.count;
    l_q         <= l_i;
    t_q         <= t_i;
    r_q         <= r_i;
    b_q         <= b_i;
  end

  assign tok_o.valid = tok_valid_q;
  assign tok_o.hit   = tok_hit_q;
  assign tok_o.count = tok_count_q;
  assign l_o         = l_q;
  assign t_o         = t_q;
  assign r_o         = r_q;
  assign b_o         = b_q;

endmodule

>>> src/label_overlap_declutter.sv
// Top level of the label overlap declutter block: checks, cell chain and result register.
// Unchecked labels, early rejections and control commands answer in the cycle after transfer.
// A label that needs the overlap scan answers once the candidate has walked the chain of
// TABLE_DEPTH cells, one cell per cycle, and its result is registered; one item is in
// flight at a time, so the input stalls while a scan is in flight.
// Reset clears the label count and loads the register defaults; stored rectangles are
// left as they are, since only slots below the count are ever read.
module label_overlap_declutter #(
  parameter int unsigned TABLE_DEPTH = ldc_pkg::TableDepthDef,
  parameter int unsigned COORD_BITS  = ldc_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ldc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ldc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ldc_pkg::CmdW-1:0]          cmd_i,
  input  logic signed [ldc_pkg::InCoordW-1:0] rect_left_i,
  input  logic signed [ldc_pkg::InCoordW-1:0] rect_top_i,
  input  logic signed [ldc_pkg::InCoordW-1:0] rect_right_i,
  input  logic signed [ldc_pkg::InCoordW-1:0] rect_bottom_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              accepted_o,
  output logic [ldc_pkg::StatusW-1:0]       status_o
);

  logic                         enable_q;
  logic [ldc_pkg::MaxLblW-1:0]  max_labels_q;
  logic signed [COORD_BITS-1:0] clip_l_q, clip_r_q, clip_t_q, clip_b_q;

  logic [ldc_pkg::CntW-1:0]     count_q, count_d;
  logic                         busy_q, busy_d;
  logic                         out_valid_q, out_valid_d;
  ldc_pkg::status_e             out_st_q, out_st_d;

  logic                         in_xfer;
  logic                         scan;
  ldc_pkg::status_e             direct_st;
  logic                         full, empty, outside;
  logic signed [COORD_BITS-1:0] c_l, c_t, c_r, c_b;
  ldc_pkg::cmd_e                cmd;

  ldc_pkg::tok_t                tok      [TABLE_DEPTH+1];
  logic signed [COORD_BITS-1:0] ch_l     [TABLE_DEPTH+1];
  logic signed [COORD_BITS-1:0] ch_t     [TABLE_DEPTH+1];
  logic signed [COORD_BITS-1:0] ch_r     [TABLE_DEPTH+1];
  logic signed [COORD_BITS-1:0] ch_b     [TABLE_DEPTH+1];
  ldc_pkg::tok_t                tok_end;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      max_labels_q <= '1;
      clip_l_q     <= '0;
      clip_r_q     <= '0;
      clip_t_q     <= '0;
      clip_b_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (ldc_pkg::cfg_idx_e'(cfg_idx_i))
        ldc_pkg::REG_ENABLE:      enable_q     <= cfg_wdata_i[0];
        ldc_pkg::REG_MAX_LABELS:  max_labels_q <= cfg_wdata_i[ldc_pkg::MaxLblW-1:0];
        ldc_pkg::REG_CLIP_LEFT:   clip_l_q     <= cfg_wdata_i[COORD_BITS-1:0];
        ldc_pkg::REG_CLIP_RIGHT:  clip_r_q     <= cfg_wdata_i[COORD_BITS-1:0];
        ldc_pkg::REG_CLIP_TOP:    clip_t_q     <= cfg_wdata_i[COORD_BITS-1:0];
        ldc_pkg::REG_CLIP_BOTTOM: clip_b_q     <= cfg_wdata_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cmd = ldc_pkg::cmd_e'(cmd_i);
  assign c_l = rect_left_i[COORD_BITS-1:0];
  assign c_t = rect_top_i[COORD_BITS-1:0];
  assign c_r = rect_right_i[COORD_BITS-1:0];
  assign c_b = rect_bottom_i[COORD_BITS-1:0];

  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Checks that need no table lookup.
  assign full    = (count_q > {1'b0, max_labels_q}) ||
                   (32'(count_q) >= 32'(TABLE_DEPTH));
  assign empty   = (c_t >= c_b) || (c_l >= c_r);
  assign outside = (c_r > clip_r_q) || (c_l < clip_l_q) ||
                   (c_b > clip_b_q) || (c_t < clip_t_q);

  always_comb begin
    scan      = 1'b0;
    direct_st = ldc_pkg::ST_CONTROL;
    unique case (cmd)
      ldc_pkg::CMD_CHECK: begin
        priority if (!enable_q) begin
          direct_st = ldc_pkg::ST_UNCHECKED;
        end else if (full) begin
          direct_st = ldc_pkg::ST_FULL;
        end else if (empty) begin
          direct_st = ldc_pkg::ST_EMPTY;
        end else if (outside) begin
          direct_st = ldc_pkg::ST_OUTSIDE;
        end else begin
          scan = 1'b1;
        end
      end
      ldc_pkg::CMD_CLEAR,
      ldc_pkg::CMD_SATURATE,
      ldc_pkg::CMD_UNUSED: direct_st = ldc_pkg::ST_CONTROL;
      default:             direct_st = ldc_pkg::ST_CONTROL;
    endcase
  end

  // Chain entry.
  assign tok[0].valid = in_xfer & scan;
  assign tok[0].hit   = 1'b0;
  assign tok[0].count = count_q;
  assign ch_l[0]      = c_l;
  assign ch_t[0]      = c_t;
  assign ch_r[0]      = c_r;
  assign ch_b[0]      = c_b;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ldc_cell #(
      .COORD_BITS(COORD_BITS),
      .IDX       (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[g]),
      .l_i   (ch_l[g]),
      .t_i   (ch_t[g]),
      .r_i   (ch_r[g]),
      .b_i   (ch_b[g]),
      .tok_o (tok[g+1]),
      .l_o   (ch_l[g+1]),
      .t_o   (ch_t[g+1]),
      .r_o   (ch_r[g+1]),
      .b_o   (ch_b[g+1])
    );
  end

  assign tok_end = tok[TABLE_DEPTH];

  // The candidate coordinates leaving the chain are not needed any further.
  logic chain_coord_tail;
  assign chain_coord_tail = ^{ch_l[TABLE_DEPTH], ch_t[TABLE_DEPTH],
                              ch_r[TABLE_DEPTH], ch_b[TABLE_DEPTH]};

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_st_d    = out_st_q;
    if (in_xfer) begin
      if (scan) begin
        busy_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        out_st_d    = direct_st;
      end
      if (cmd == ldc_pkg::CMD_CLEAR) begin
        count_d = '0;
      end else if (cmd == ldc_pkg::CMD_SATURATE) begin
        count_d = ldc_pkg::CntW'(max_labels_q) + ldc_pkg::CntW'(1);
      end
    end
    if (tok_end.valid) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (tok_end.hit) begin
        out_st_d = ldc_pkg::ST_OVERLAP;
      end else begin
        out_st_d = ldc_pkg::ST_INSERTED;
        count_d  = tok_end.count + ldc_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_st_q <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign accepted_o  = (out_st_q == ldc_pkg::ST_INSERTED) ||
                       (out_st_q == ldc_pkg::ST_UNCHECKED) ||
                       (chain_coord_tail & 1'b0);

endmodule
